/* sv/cop_pkg.sv */
// Shared constants, queue item type and state codes for the overlap projection core.
package cop_pkg;

  localparam int COEFF_WIDTH = 16;
  localparam int ACC_WIDTH   = 48;
  localparam int W_WIDTH     = 16;
  localparam int TOT_W       = 63;
  localparam int DIG_W       = 16;

  localparam int PROD_C     = 2 * COEFF_WIDTH;
  localparam int SUM_W      = ((ACC_WIDTH > PROD_C) ? ACC_WIDTH : PROD_C) + 2;
  localparam int MAG_W      = ACC_WIDTH;
  localparam int SQ_W       = 2 * MAG_W + 1;
  localparam int PROD_W     = SQ_W + W_WIDTH;
  localparam int TERM_SHIFT = 2 * (COEFF_WIDTH - 1) + 16;
  localparam int NDM        = (MAG_W + DIG_W - 1) / DIG_W;
  localparam int NDS        = (SQ_W + DIG_W - 1) / DIG_W;
  localparam int KW         = $clog2(NDS);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one classified item as it travels from the front to the back
  typedef struct packed {
    logic [PROD_C-1:0]  p_rr;
    logic [PROD_C-1:0]  p_ii;
    logic [PROD_C-1:0]  p_ir;
    logic [PROD_C-1:0]  p_ri;
    logic               band_end;
    logic               occupied;
    logic [W_WIDTH-1:0] weight;
    logic               set_end;
  } cop_item_t;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ADD1 = 9'b000000010,
    ST_ADD2 = 9'b000000100,
    ST_MAG  = 9'b000001000,
    ST_SQR  = 9'b000010000,
    ST_SQI  = 9'b000100000,
    ST_WGT  = 9'b001000000,
    ST_TERM = 9'b010000000,
    ST_TOT  = 9'b100000000
  } cop_state_t;

endpackage

/* sv/cop_if.sv */
// Handshake channel interfaces for coefficient items and overlap results.
interface cop_in_if;
  import cop_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COEFF_WIDTH-1:0] proj_re;
  logic signed [COEFF_WIDTH-1:0] proj_im;
  logic signed [COEFF_WIDTH-1:0] ref_re;
  logic signed [COEFF_WIDTH-1:0] ref_im;
  logic                          last_wave;
  logic                          occupied;
  logic [W_WIDTH-1:0]            kpoint_weight;
  logic                          last_of_set;

  modport source (output valid, proj_re, proj_im, ref_re, ref_im, last_wave, occupied,
                  kpoint_weight, last_of_set, input ready);
  modport sink (input valid, proj_re, proj_im, ref_re, ref_im, last_wave, occupied,
                kpoint_weight, last_of_set, output ready);
endinterface

interface cop_out_if;
  import cop_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] overlap_re;
  logic signed [ACC_WIDTH-1:0] overlap_im;
  logic [TOT_W-1:0]            valence_total;
  logic [TOT_W-1:0]            conduction_total;
  logic                        set_done;

  modport source (output valid, overlap_re, overlap_im, valence_total, conduction_total,
                  set_done, input ready);
  modport sink (input valid, overlap_re, overlap_im, valence_total, conduction_total,
                set_done, output ready);
endinterface

/* sv/cop_front.sv */
// Front end: input stage register, the four coefficient products, push into the queue.
module cop_front (
  input  logic                clk,
  input  logic                rst_n,
  cop_in_if.sink              in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output cop_pkg::cop_item_t  push_item
);
  import cop_pkg::*;

  logic                          stg_v_r, stg_v_nxt;
  logic signed [COEFF_WIDTH-1:0] pr_r, pi_r, rr_r, ri_r;
  logic                          lw_r, occ_r, lset_r;
  logic [W_WIDTH-1:0]            w_r;
  logic signed [PROD_C-1:0]      m_rr, m_ii, m_ir, m_ri;
  logic                          accept;

  assign in_ch.ready = !stg_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = stg_v_r;

  assign m_rr = pr_r * rr_r;
  assign m_ii = pi_r * ri_r;
  assign m_ir = pi_r * rr_r;
  assign m_ri = pr_r * ri_r;

  always_comb begin
    push_item          = '0;
    push_item.p_rr     = m_rr;
    push_item.p_ii     = m_ii;
    push_item.p_ir     = m_ir;
    push_item.p_ri     = m_ri;
    push_item.band_end = lw_r;
    push_item.occupied = occ_r;
    push_item.weight   = w_r;
    push_item.set_end  = lset_r;
  end

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (accept) begin
      stg_v_nxt = 1'b1;
    end else if (push_ready) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pr_r   <= in_ch.proj_re;
      pi_r   <= in_ch.proj_im;
      rr_r   <= in_ch.ref_re;
      ri_r   <= in_ch.ref_im;
      lw_r   <= in_ch.last_wave;
      occ_r  <= in_ch.occupied;
      w_r    <= in_ch.kpoint_weight;
      lset_r <= in_ch.last_of_set;
    end
  end

endmodule

/* sv/cop_queue.sv */
// Short item queue between front and back.
module cop_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  cop_pkg::cop_item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cop_pkg::cop_item_t  pop_item
);
  import cop_pkg::*;

  cop_item_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? QAW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop ? QAW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

/* sv/cop_back.sv */
// Back end: saturating overlap accumulation, digit-serial weighted term, totals, result register.
module cop_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  cop_pkg::cop_item_t  pop_item,
  cop_out_if.source           out_ch
);
  import cop_pkg::*;

  localparam int MPW  = NDM * DIG_W;
  localparam int SPW  = NDS * DIG_W;
  localparam int PADW = PROD_W + TOT_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_MAX_S = SUM_W'({(ACC_WIDTH-1){1'b1}});
  localparam logic signed [SUM_W-1:0] ACC_MIN_S = ~ACC_MAX_S;

  function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic signed [SUM_W-1:0] s);
    logic [ACC_WIDTH-1:0] r;
    if (s > ACC_MAX_S) begin
      r = ACC_MAX_S[ACC_WIDTH-1:0];
    end else if (s < ACC_MIN_S) begin
      r = ACC_MIN_S[ACC_WIDTH-1:0];
    end else begin
      r = s[ACC_WIDTH-1:0];
    end
    return r;
  endfunction

  cop_state_t              st_r, st_nxt;
  cop_item_t               it_r, it_nxt;
  logic [ACC_WIDTH-1:0]    re_r, re_nxt, im_r, im_nxt;
  logic [TOT_W-1:0]        val_r, val_nxt, con_r, con_nxt;
  logic [MAG_W-1:0]        ur_r, ur_nxt, ui_r, ui_nxt;
  logic [SQ_W-1:0]         s_r, s_nxt;
  logic [PROD_W-1:0]       p_r, p_nxt;
  logic [TOT_W-1:0]        term_r, term_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic                    ov_r, ov_nxt;
  logic [ACC_WIDTH-1:0]    o_re_r, o_re_nxt, o_im_r, o_im_nxt;
  logic [TOT_W-1:0]        o_val_r, o_val_nxt, o_con_r, o_con_nxt;
  logic                    o_set_r, o_set_nxt;

  logic signed [SUM_W-1:0] re_ext, im_ext, a_re, a_im, sum_re, sum_im;
  logic [MPW-1:0]          ur_pad, ui_pad;
  logic [SPW-1:0]          s_pad;
  logic [DIG_W-1:0]        dig_m, dig_s;
  logic [MAG_W-1:0]        sq_opnd;
  logic [MAG_W+DIG_W-1:0]  sq_part;
  logic [2*DIG_W-1:0]      wt_part;
  logic [PADW-1:0]         shifted;
  logic [TOT_W:0]          tot_sum;
  logic [TOT_W-1:0]        tot_sat, tot_sel;
  logic                    out_free;

  assign re_ext = SUM_W'($signed(re_r));
  assign im_ext = SUM_W'($signed(im_r));

  // first half adds pr*rr / pi*rr, second half adds pi*ri / subtracts pr*ri
  always_comb begin
    if (st_r == ST_ADD1) begin
      a_re = SUM_W'($signed(it_r.p_rr));
      a_im = SUM_W'($signed(it_r.p_ir));
    end else begin
      a_re = SUM_W'($signed(it_r.p_ii));
      a_im = -SUM_W'($signed(it_r.p_ri));
    end
  end
  assign sum_re = re_ext + a_re;
  assign sum_im = im_ext + a_im;

  assign ur_pad  = MPW'(ur_r);
  assign ui_pad  = MPW'(ui_r);
  assign s_pad   = SPW'(s_r);
  assign dig_m   = (st_r == ST_SQR) ? ur_pad[k_r*DIG_W +: DIG_W] : ui_pad[k_r*DIG_W +: DIG_W];
  assign sq_opnd = (st_r == ST_SQR) ? ur_r : ui_r;
  assign sq_part = sq_opnd * dig_m;
  assign dig_s   = s_pad[k_r*DIG_W +: DIG_W];
  assign wt_part = dig_s * it_r.weight;

  assign shifted = PADW'(p_r) >> TERM_SHIFT;

  assign tot_sel = it_r.occupied ? val_r : con_r;
  assign tot_sum = {1'b0, tot_sel} + {1'b0, term_r};
  assign tot_sat = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];

  assign out_free  = !ov_r || out_ch.ready;
  assign pop_ready = (st_r == ST_IDLE) ||
                     ((st_r == ST_ADD2) && !it_r.band_end);

  always_comb begin
    st_nxt    = st_r;
    it_nxt    = it_r;
    re_nxt    = re_r;
    im_nxt    = im_r;
    val_nxt   = val_r;
    con_nxt   = con_r;
    ur_nxt    = ur_r;
    ui_nxt    = ui_r;
    s_nxt     = s_r;
    p_nxt     = p_r;
    term_nxt  = term_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && !out_ch.ready;
    o_re_nxt  = o_re_r;
    o_im_nxt  = o_im_r;
    o_val_nxt = o_val_r;
    o_con_nxt = o_con_r;
    o_set_nxt = o_set_r;
    case (st_r)
      ST_IDLE: begin
        if (pop_valid) begin
          it_nxt = pop_item;
          st_nxt = ST_ADD1;
        end
      end
      ST_ADD1: begin
        re_nxt = sat_acc(sum_re);
        im_nxt = sat_acc(sum_im);
        st_nxt = ST_ADD2;
      end
      ST_ADD2: begin
        re_nxt = sat_acc(sum_re);
        im_nxt = sat_acc(sum_im);
        if (it_r.band_end) begin
          st_nxt = ST_MAG;
        end else if (pop_valid) begin
          it_nxt = pop_item;
          st_nxt = ST_ADD1;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_MAG: begin
        // magnitude of the most negative value still fits unsigned
        ur_nxt = re_r[ACC_WIDTH-1] ? ACC_WIDTH'(~re_r + 1'b1) : re_r;
        ui_nxt = im_r[ACC_WIDTH-1] ? ACC_WIDTH'(~im_r + 1'b1) : im_r;
        s_nxt  = '0;
        k_nxt  = '0;
        st_nxt = ST_SQR;
      end
      ST_SQR, ST_SQI: begin
        s_nxt = s_r + (SQ_W'(sq_part) << (k_r * DIG_W));
        if (k_r == KW'(NDM - 1)) begin
          k_nxt  = '0;
          st_nxt = (st_r == ST_SQR) ? ST_SQI : ST_WGT;
          p_nxt  = '0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_WGT: begin
        p_nxt = p_r + (PROD_W'(wt_part) << (k_r * DIG_W));
        if (k_r == KW'(NDS - 1)) begin
          k_nxt  = '0;
          st_nxt = ST_TERM;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_TERM: begin
        term_nxt = (|shifted[PADW-1:TOT_W]) ? {TOT_W{1'b1}} : shifted[TOT_W-1:0];
        st_nxt   = ST_TOT;
      end
      ST_TOT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_re_nxt  = re_r;
          o_im_nxt  = im_r;
          o_val_nxt = it_r.occupied ? tot_sat : val_r;
          o_con_nxt = it_r.occupied ? con_r : tot_sat;
          o_set_nxt = it_r.set_end;
          re_nxt    = '0;
          im_nxt    = '0;
          if (it_r.set_end) begin
            val_nxt = '0;
            con_nxt = '0;
          end else if (it_r.occupied) begin
            val_nxt = tot_sat;
          end else begin
            con_nxt = tot_sat;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      ov_r  <= 1'b0;
      re_r  <= '0;
      im_r  <= '0;
      val_r <= '0;
      con_r <= '0;
      k_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      ov_r  <= ov_nxt;
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      val_r <= val_nxt;
      con_r <= con_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r    <= it_nxt;
    ur_r    <= ur_nxt;
    ui_r    <= ui_nxt;
    s_r     <= s_nxt;
    p_r     <= p_nxt;
    term_r  <= term_nxt;
    o_re_r  <= o_re_nxt;
    o_im_r  <= o_im_nxt;
    o_val_r <= o_val_nxt;
    o_con_r <= o_con_nxt;
    o_set_r <= o_set_nxt;
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.overlap_re       = o_re_r;
  assign out_ch.overlap_im       = o_im_r;
  assign out_ch.valence_total    = o_val_r;
  assign out_ch.conduction_total = o_con_r;
  assign out_ch.set_done         = o_set_r;

endmodule

/* sv/complex_overlap_projection_core.sv */
// Top level of the complex overlap projection core.
// Each input item carries one projected and one reference Q1.15 coefficient
// pair. The front registers the item, forms the four coefficient products and
// pushes them into a four-entry queue, so it takes one item per cycle until
// the queue fills. The back adds P*conj(R) into saturating Q18.30 overlap
// accumulators in two saturating add steps per item (ADD1, ADD2), back to
// back while the queue holds items. An item that ends a band then runs the
// magnitude, the squares of its real and imaginary parts (which share one
// 16-bit-digit multiply-add) and the k-point weighting (a second digit
// multiply-add), then the term shift and the total update; the result is then
// written to the output register, which holds it until taken while the front
// keeps accepting. Totals clamp at 2^63-1 and clear after set end.
module complex_overlap_projection_core (
  input  logic     clk,
  input  logic     rst_n,
  cop_in_if.sink   in_ch,
  cop_out_if.source out_ch
);
  import cop_pkg::*;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  cop_item_t push_item, pop_item;

  cop_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  cop_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  cop_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule
